>>> rtl/ckm_pkg.sv
// Shared types, constants and helpers for the color k-means cluster unit.
// Used by every module under rtl/.
`default_nettype none
package ckm_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_AW + 1;
  localparam int MAX_CL     = 16;
  localparam int CL_W       = 4;
  localparam int K_W        = 5;
  localparam int CH_W       = 8;
  localparam int PT_W       = 3 * CH_W;
  localparam int SQ_W       = 2 * CH_W;
  localparam int SQAB_W     = SQ_W + 1;
  localparam int DIST_W     = 34;
  localparam int ROOT_W     = 17;
  localparam int RSUM_W     = ROOT_W + CL_W;
  localparam int SUM_W      = CH_W + PT_AW;
  localparam int DRAIN_LEN  = 2 * MAX_CL + 1;
  localparam int DRAIN_W    = $clog2(DRAIN_LEN + 1);
  localparam logic [13:0] WL_Q16 = 14'd10079;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic CFG_CLUSTERS = 1'b0;
  localparam logic CFG_MAX_ITER = 1'b1;

  typedef logic [PT_W-1:0] pt_t;

  // word moving down the cell row: a point and the best match so far
  typedef struct packed {
    logic              vld;
    pt_t               pt;
    logic [DIST_W-1:0] best_d;
    logic [CL_W-1:0]   idx;
  } link_t;

  typedef struct packed {
    logic [SQ_W-1:0]   sq_l;
    logic [SQAB_W-1:0] sq_ab;
  } sq_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_INIT_LD, ST_CLR, ST_FEED, ST_DRAIN, ST_SORT, ST_FILL,
    ST_DIV, ST_FAR_RD, ST_FAR_SQ, ST_FAR_D, ST_FAR_RT, ST_COMMIT, ST_EMIT
  } state_t;

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic sq_t squares(input pt_t p, input pt_t c);
    logic [CH_W-1:0] dl, da, db;
    sq_t s;
    dl = absdiff(p[CH_W-1:0], c[CH_W-1:0]);
    da = absdiff(p[2*CH_W-1:CH_W], c[2*CH_W-1:CH_W]);
    db = absdiff(p[3*CH_W-1:2*CH_W], c[3*CH_W-1:2*CH_W]);
    s.sq_l  = SQ_W'(dl) * SQ_W'(dl);
    s.sq_ab = SQAB_W'(SQ_W'(da) * SQ_W'(da)) + SQAB_W'(SQ_W'(db) * SQ_W'(db));
    return s;
  endfunction

  // Q16 squared distance, L term weighted by (100/255)^2
  function automatic logic [DIST_W-1:0] dist_of(input sq_t s);
    return DIST_W'(s.sq_l) * DIST_W'(WL_Q16) + {1'b0, s.sq_ab, 16'd0};
  endfunction

endpackage
`default_nettype wire

>>> rtl/ckm_cell.sv
// One cell of the distance row: holds one center, compares a passing point
// against it and forwards the better match. Depends on ckm_pkg.
`default_nettype none
module ckm_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic [ckm_pkg::CL_W-1:0] cell_idx,
  input  wire logic                  ctr_wr,
  input  wire ckm_pkg::pt_t          ctr_in,
  input  wire ckm_pkg::link_t        link_in,
  output ckm_pkg::link_t             link_out,
  output ckm_pkg::pt_t               ctr
);
  import ckm_pkg::*;

  link_t             a_link;
  sq_t               a_sq;
  logic [DIST_W-1:0] d;

  always_ff @(posedge clk) begin
    if (ctr_wr) begin
      ctr <= ctr_in;
    end
    a_sq <= squares(link_in.pt, ctr);
    if (rst) begin
      a_link <= '0;
    end else begin
      a_link <= link_in;
    end
  end

  assign d = dist_of(a_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.vld <= a_link.vld;
      link_out.pt  <= a_link.pt;
      // strict less keeps the lower index on ties
      if (en && d < a_link.best_d) begin
        link_out.best_d <= d;
        link_out.idx    <= cell_idx;
      end else begin
        link_out.best_d <= a_link.best_d;
        link_out.idx    <= a_link.idx;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ckm_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on ckm_pkg.
`default_nettype none
module ckm_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ckm_pkg::DIST_W-1:0] val,
  output logic                           busy,
  output logic                           done,
  output logic [ckm_pkg::ROOT_W-1:0]     root
);
  import ckm_pkg::*;

  localparam int RW = DIST_W + 1;

  logic [RW-1:0] rem, res, bitv, trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      rem  <= RW'(val);
      res  <= '0;
      bitv <= RW'(1) << (2 * ROOT_W - 2);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      done <= bitv[0];
      if (bitv[0]) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ckm_div.sv
// Restoring divider for the cluster means, one quotient bit per cycle.
// Depends on ckm_pkg.
`default_nettype none
module ckm_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ckm_pkg::SUM_W-1:0] num,
  input  wire logic [ckm_pkg::CNT_W-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic [ckm_pkg::SUM_W-1:0]      quo
);
  import ckm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CNT_W:0]      rem, rem_sh;
  logic [CNT_W-1:0]    dsr;
  logic [STEP_W-1:0]   step;

  assign rem_sh = {rem[CNT_W-1:0], quo[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      rem  <= '0;
      quo  <= num;
      dsr  <= den;
      step <= STEP_W'(SUM_W);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dsr}) begin
        rem <= rem_sh - {1'b0, dsr};
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
      step <= step - 1'b1;
      done <= (step == STEP_W'(1));
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/color_kmeans_cluster_unit.sv
// Top level of the color k-means cluster unit: point store, cell row,
// pass sequencer and result port. Depends on ckm_pkg, ckm_cell, ckm_isqrt, ckm_div.
`default_nettype none
// Load words (tuser = 0) are taken one per cycle into a 4096-entry point store;
// loads past the store size are dropped. A start word (tuser = 1) clusters the
// loaded points with k = min(cluster_count, 16, points), a cluster_count of 0
// counting as 1, and takes no more words until the last center has gone into
// the output register. Each pass streams the N points through a row of 16
// distance cells, then sorts the clusters and forms the means with a serial
// divider. A pass with an empty cluster runs one farthest-point scan, shared
// by all its empty clusters, its time dominated by the serial square root.
// Up to max_iterations passes run; k centers then follow, one word each, with
// tlast on the last one.
module color_kmeans_cluster_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // chan_l, chan_a, chan_b
  input  wire logic        s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // center_index, center_l, center_a, center_b, zero pad
  output logic             m_tuser,   // converged
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [7:0]  cfg_data
);
  import ckm_pkg::*;

  state_t state, state_next;

  logic [K_W-1:0]    cl_cnt;
  logic [CH_W-1:0]   max_it;
  logic [CNT_W-1:0]  pt_count;
  logic [K_W-1:0]    k, k_calc, k_req;

  pt_t               pt_mem [MAX_POINTS];
  logic              rd_en, rd_vld, rd_feed;
  pt_t               rd_data;
  logic [CL_W-1:0]   rd_tag;

  logic [CNT_W-1:0]  cnt;
  logic [K_W-1:0]    pos, j;
  logic [1:0]        ch;
  logic [DRAIN_W-1:0] drain;
  logic [CH_W-1:0]   iter;
  logic              conv, far_done, found;
  logic [RSUM_W-1:0] rsum, rsum_new, best_rs;
  pt_t               far_pt;
  pt_t               fresh [MAX_CL];
  logic [CL_W-1:0]   order [MAX_CL];
  logic [MAX_CL-1:0] used;
  logic [CNT_W-1:0]  best_sz;
  logic [CL_W-1:0]   best_j, sel_j, src;
  logic              take, changed;
  sq_t               f_sq;

  link_t             link [MAX_CL+1];
  pt_t               ctr_q [MAX_CL];
  logic [MAX_CL-1:0] ctr_wr;

  logic [SUM_W-1:0]  sums [MAX_CL][3];
  logic [CNT_W-1:0]  sizes [MAX_CL];

  logic              load_acc, start_acc, emit_ld, last_pos, j_last;
  logic              div_start, div_busy, div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [1:0]        div_ch;
  logic              rt_start, rt_busy, rt_done;
  logic [ROOT_W-1:0] rt_root;

  // ---------------- config and k ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cl_cnt <= K_W'(8);
      max_it <= CH_W'(16);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CLUSTERS: cl_cnt <= cfg_data[K_W-1:0];
        CFG_MAX_ITER: max_it <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    k_req = (cl_cnt == '0) ? K_W'(1) : cl_cnt;
    if (k_req > K_W'(MAX_CL)) begin
      k_req = K_W'(MAX_CL);
    end
    k_calc = (CNT_W'(k_req) > pt_count) ? pt_count[K_W-1:0] : k_req;
  end

  assign s_tready  = (state == ST_IDLE);
  assign load_acc  = s_tvalid && s_tready && (s_tuser == KIND_LOAD);
  assign start_acc = s_tvalid && s_tready && (s_tuser == KIND_START);

  // ---------------- point store ----------------
  always_comb begin
    case (state)
      ST_INIT:   rd_en = (cnt < CNT_W'(k));
      ST_FEED:   rd_en = 1'b1;
      ST_FAR_RD: rd_en = 1'b1;
      default:   rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_acc && pt_count < CNT_W'(MAX_POINTS)) begin
      pt_mem[pt_count[PT_AW-1:0]] <= s_tdata;
    end
    if (rd_en) begin
      rd_data <= pt_mem[cnt[PT_AW-1:0]];
    end
    rd_tag <= cnt[CL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      rd_feed <= 1'b0;
    end else begin
      rd_vld  <= rd_en && (state == ST_INIT);
      rd_feed <= rd_en && (state == ST_FEED);
    end
  end

  // ---------------- cell row ----------------
  assign link[0] = '{vld: rd_feed, pt: rd_data, best_d: '1, idx: '0};

  for (genvar gi = 0; gi < MAX_CL; gi++) begin : g_cell
    assign ctr_wr[gi] = ((state == ST_COMMIT) || (state == ST_INIT_LD)) &&
                        (K_W'(gi) < k);
    ckm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (K_W'(gi) < k),
      .cell_idx (CL_W'(gi)),
      .ctr_wr   (ctr_wr[gi]),
      .ctr_in   (fresh[gi]),
      .link_in  (link[gi]),
      .link_out (link[gi+1]),
      .ctr      (ctr_q[gi])
    );
  end

  // cluster accumulators
  always_ff @(posedge clk) begin
    if (state == ST_CLR) begin
      for (int i = 0; i < MAX_CL; i++) begin
        sizes[i] <= '0;
        for (int c = 0; c < 3; c++) begin
          sums[i][c] <= '0;
        end
      end
    end else if (link[MAX_CL].vld) begin
      sizes[link[MAX_CL].idx] <= sizes[link[MAX_CL].idx] + 1'b1;
      for (int c = 0; c < 3; c++) begin
        sums[link[MAX_CL].idx][c] <= sums[link[MAX_CL].idx][c] +
                                     SUM_W'(link[MAX_CL].pt[c*CH_W +: CH_W]);
      end
    end
  end

  // ---------------- helpers ----------------
  assign last_pos = (pos == k - 1'b1);
  assign j_last   = (j == k - 1'b1);
  assign take     = (j < k) && !used[j[CL_W-1:0]] &&
                    (!found || sizes[j[CL_W-1:0]] > best_sz);
  assign sel_j    = take ? j[CL_W-1:0] : best_j;
  assign src      = order[pos[CL_W-1:0]];
  assign emit_ld  = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign rsum_new = rsum + RSUM_W'(rt_root);

  always_comb begin
    changed = 1'b0;
    for (int i = 0; i < MAX_CL; i++) begin
      if (K_W'(i) < k && fresh[i] != ctr_q[i]) begin
        changed = 1'b1;
      end
    end
  end

  assign div_start = ((state == ST_FILL) && sizes[src] != '0) ||
                     ((state == ST_DIV) && div_done && ch != 2'd2);
  assign div_ch    = (state == ST_DIV) ? ch + 1'b1 : 2'd0;
  assign rt_start  = (state == ST_FAR_D);

  ckm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sums[src][div_ch]),
    .den   (sizes[src]),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  ckm_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (rt_start),
    .val   (dist_of(f_sq)),
    .busy  (rt_busy),
    .done  (rt_done),
    .root  (rt_root)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start_acc && k_calc != '0) state_next = ST_INIT;
      ST_INIT:    if (cnt == CNT_W'(k)) state_next = ST_INIT_LD;
      ST_INIT_LD: state_next = (max_it == '0) ? ST_EMIT : ST_CLR;
      ST_CLR:     state_next = ST_FEED;
      ST_FEED:    if (cnt == pt_count - 1'b1) state_next = ST_DRAIN;
      ST_DRAIN:   if (drain == DRAIN_W'(DRAIN_LEN)) state_next = ST_SORT;
      ST_SORT:    if (j_last && last_pos) state_next = ST_FILL;
      ST_FILL: begin
        if (sizes[src] != '0) begin
          state_next = ST_DIV;
        end else if (!far_done) begin
          state_next = ST_FAR_RD;
        end else if (last_pos) begin
          state_next = ST_COMMIT;
        end
      end
      ST_DIV:     if (div_done && ch == 2'd2) state_next = last_pos ? ST_COMMIT : ST_FILL;
      ST_FAR_RD:  state_next = ST_FAR_SQ;
      ST_FAR_SQ:  state_next = ST_FAR_D;
      ST_FAR_D:   state_next = ST_FAR_RT;
      ST_FAR_RT: begin
        if (rt_done) begin
          if (!j_last) begin
            state_next = ST_FAR_SQ;
          end else if (cnt == pt_count - 1'b1) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_FAR_RD;
          end
        end
      end
      ST_COMMIT:  state_next = (!changed || iter + 1'b1 == max_it) ? ST_EMIT : ST_CLR;
      ST_EMIT:    if (emit_ld && last_pos) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_count <= '0;
      k        <= '0;
      far_done <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (load_acc && pt_count < CNT_W'(MAX_POINTS)) begin
            pt_count <= pt_count + 1'b1;
          end
          if (start_acc) begin
            k <= k_calc;
            if (k_calc == '0) begin
              pt_count <= '0;
            end
          end
        end
        ST_INIT: begin
          if (rd_en) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_vld) begin
            fresh[rd_tag] <= rd_data;
          end
        end
        ST_INIT_LD: begin
          iter <= '0;
          conv <= 1'b0;
          pos  <= '0;
        end
        ST_CLR: begin
          cnt      <= '0;
          drain    <= '0;
          far_done <= 1'b0;
        end
        ST_FEED: begin
          cnt <= cnt + 1'b1;
        end
        ST_DRAIN: begin
          drain <= drain + 1'b1;
          pos   <= '0;
          j     <= '0;
          used  <= '0;
          found <= 1'b0;
        end
        ST_SORT: begin
          if (take && !j_last) begin
            found   <= 1'b1;
            best_sz <= sizes[j[CL_W-1:0]];
            best_j  <= j[CL_W-1:0];
          end
          if (j_last) begin
            order[pos[CL_W-1:0]] <= sel_j;
            used[sel_j] <= 1'b1;
            found <= 1'b0;
            j     <= '0;
            pos   <= last_pos ? '0 : pos + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_FILL: begin
          ch   <= '0;
          cnt  <= '0;
          j    <= '0;
          rsum <= '0;
          if (sizes[src] == '0 && far_done) begin
            fresh[pos[CL_W-1:0]] <= far_pt;
            if (!last_pos) begin
              pos <= pos + 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            fresh[pos[CL_W-1:0]][ch*CH_W +: CH_W] <= div_quo[CH_W-1:0];
            ch <= ch + 1'b1;
            if (ch == 2'd2 && !last_pos) begin
              pos <= pos + 1'b1;
            end
          end
        end
        ST_FAR_SQ: begin
          f_sq <= squares(rd_data, ctr_q[j[CL_W-1:0]]);
        end
        ST_FAR_RT: begin
          if (rt_done) begin
            if (j_last) begin
              if (cnt == '0 || rsum_new > best_rs) begin
                best_rs <= rsum_new;
                far_pt  <= rd_data;
              end
              j    <= '0;
              rsum <= '0;
              cnt  <= cnt + 1'b1;
              if (cnt == pt_count - 1'b1) begin
                far_done <= 1'b1;
              end
            end else begin
              j    <= j + 1'b1;
              rsum <= rsum_new;
            end
          end
        end
        ST_COMMIT: begin
          iter <= iter + 1'b1;
          conv <= !changed;
          pos  <= '0;
        end
        ST_EMIT: begin
          if (emit_ld) begin
            pos <= pos + 1'b1;
            if (last_pos) begin
              pt_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit_ld) begin
      m_tdata  <= {4'd0, ctr_q[pos[CL_W-1:0]], pos[CL_W-1:0]};
      m_tuser  <= conv;
      m_tlast  <= last_pos;
    end
  end

  // ---------------- checks ----------------
  a_chain_in_pass: assert property (@(posedge clk) disable iff (rst)
    link[MAX_CL].vld |-> (state == ST_FEED || state == ST_DRAIN))
    else $error("cell row output outside a pass");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL || state == ST_DIV) |-> (pos < k))
    else $error("fill position beyond cluster count");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    rt_start |-> !rt_busy)
    else $error("square root restarted while busy");

endmodule
`default_nettype wire

>>> test/ckm_center_checker.sv
// Checker for the color k-means cluster unit: watches the word and config ports,
// predicts the emitted centers and compares them. Depends on ckm_pkg.
module ckm_center_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          centers_seen
);
  import ckm_pkg::*;

  typedef struct packed {
    logic [3:0] idx;
    pt_t        c;
    logic       conv;
    logic       last;
  } center_t;

  pt_t         pts[MAX_POINTS];
  int unsigned npts;
  pt_t         centers[MAX_CL];
  logic [4:0]  k_reg;
  logic [7:0]  iter_reg;
  center_t     expected_centers[$];

  function automatic longint unsigned wdist(pt_t p, pt_t c);
    longint unsigned dl, da, db;
    dl = (p[7:0] > c[7:0]) ? p[7:0] - c[7:0] : c[7:0] - p[7:0];
    da = (p[15:8] > c[15:8]) ? p[15:8] - c[15:8] : c[15:8] - p[15:8];
    db = (p[23:16] > c[23:16]) ? p[23:16] - c[23:16] : c[23:16] - p[23:16];
    return dl * dl * longint'(WL_Q16) + (da * da + db * db) * 65536;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // empty cluster: point with strictly largest summed distance to old centers
  function automatic pt_t farthest(int k);
    longint unsigned best, s;
    int pick;
    best = 0;
    pick = 0;
    for (int i = 0; i < npts; i++) begin
      s = 0;
      for (int c = 0; c < k; c++) s += root64(wdist(pts[i], centers[c]));
      if (s > best) begin
        best = s;
        pick = i;
      end
    end
    return pts[pick];
  endfunction

  task automatic lloyd_pass(input int k, output bit moved);
    int unsigned sums[MAX_CL][3];
    int unsigned sizes[MAX_CL];
    int order[MAX_CL];
    pt_t fresh[MAX_CL];
    longint unsigned bd, d;
    int best, j, src;
    int unsigned n;
    for (int c = 0; c < k; c++) begin
      sizes[c] = 0;
      for (int h = 0; h < 3; h++) sums[c][h] = 0;
    end
    for (int i = 0; i < npts; i++) begin
      bd = wdist(pts[i], centers[0]);
      best = 0;
      for (int c = 1; c < k; c++) begin
        d = wdist(pts[i], centers[c]);
        if (d < bd) begin
          bd = d;
          best = c;
        end
      end
      sums[best][0] += pts[i][7:0];
      sums[best][1] += pts[i][15:8];
      sums[best][2] += pts[i][23:16];
      sizes[best]++;
    end
    // stable order by size, largest first
    for (int i = 0; i < k; i++) begin
      j = i;
      while (j > 0 && sizes[order[j-1]] < sizes[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < k; i++) begin
      src = order[i];
      n = sizes[src];
      if (n != 0)
        fresh[i] = {8'(sums[src][2] / n), 8'(sums[src][1] / n), 8'(sums[src][0] / n)};
      else
        fresh[i] = farthest(k);
    end
    moved = 0;
    for (int i = 0; i < k; i++) if (centers[i] != fresh[i]) moved = 1;
    for (int i = 0; i < k; i++) centers[i] = fresh[i];
  endtask

  task automatic cluster_run();
    int k;
    bit conv, moved;
    center_t e;
    k = (k_reg == 0) ? 1 : k_reg;
    if (k > MAX_CL) k = MAX_CL;
    if (k > npts) k = npts;
    if (k != 0) begin
      for (int i = 0; i < k; i++) centers[i] = pts[i];
      conv = 0;
      for (int it = 0; it < iter_reg; it++) begin
        lloyd_pass(k, moved);
        if (!moved) begin
          conv = 1;
          break;
        end
      end
      for (int i = 0; i < k; i++) begin
        e.idx = 4'(i);
        e.c = centers[i];
        e.conv = conv;
        e.last = (i + 1 == k);
        expected_centers.insert(expected_centers.size(), e);
      end
    end
    npts = 0;
  endtask

  task automatic note_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH center %0d: %s got %0d expected %0d", centers_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    center_t e;
    if (rst) begin
      npts = 0;
      k_reg = 5'd8;
      iter_reg = 8'd16;
      expected_centers.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_CLUSTERS) k_reg = cfg_data[4:0];
        else iter_reg = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_LOAD) begin
          if (npts < MAX_POINTS) begin
            pts[npts] = s_tdata;
            npts++;
          end
        end else begin
          cluster_run();
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_centers.size() == 0) begin
          note_mismatch("unexpected word, tdata", m_tdata, 0);
        end else begin
          e = expected_centers.pop_front();
          if (m_tdata[3:0] != e.idx) note_mismatch("center_index", m_tdata[3:0], e.idx);
          if (m_tdata[11:4] != e.c[7:0]) note_mismatch("center_l", m_tdata[11:4], e.c[7:0]);
          if (m_tdata[19:12] != e.c[15:8]) note_mismatch("center_a", m_tdata[19:12], e.c[15:8]);
          if (m_tdata[27:20] != e.c[23:16])
            note_mismatch("center_b", m_tdata[27:20], e.c[23:16]);
          if (m_tuser != e.conv) note_mismatch("converged", m_tuser, e.conv);
          if (m_tlast != e.last) note_mismatch("last_center", m_tlast, e.last);
        end
        centers_seen++;
      end
    end
    pending <= expected_centers.size();
  end
endmodule

>>> test/color_kmeans_cluster_unit_tb.sv
// Stimulus and verdict for the color k-means cluster unit; results are judged
// by ckm_center_checker. Depends on ckm_pkg and the RTL top.
module color_kmeans_cluster_unit_tb;
  import ckm_pkg::*;

  localparam int CYCLE_LIMIT = 30_000_000;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tuser;
  logic [23:0] s_tdata;
  logic        m_tvalid, m_tready, m_tuser, m_tlast;
  logic [31:0] m_tdata;
  logic        cfg_we, cfg_idx;
  logic [7:0]  cfg_data;
  int          errors, pending, centers_seen;

  int  words_in, starts, rand_items, rx_hold, cycles;
  bit  tx_gaps, rx_gaps;

  color_kmeans_cluster_unit dut (.*);

  ckm_center_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d centers still due", cycles, pending);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver side: random stalls, plus a long hold on request
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 0;
        rx_hold--;
      end else begin
        m_tready <= !rx_gaps || ($urandom_range(99) >= 33);
      end
    end
  end

  // with tx_gaps set, an idle gap on the sender side comes before a random half of the words
  task automatic push_word(input logic kind, input pt_t p);
    if (tx_gaps && $urandom_range(99) < 50) begin
      @(negedge clk);
      s_tvalid <= 0;
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    words_in++;
    if (kind == KIND_START) starts++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_cfg(input int k, input int iters);
    wait_idle();
    cfg_we <= 1;
    cfg_idx <= CFG_CLUSTERS;
    cfg_data <= 8'(k);
    @(negedge clk);
    cfg_idx <= CFG_MAX_ITER;
    cfg_data <= 8'(iters);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] jitter(logic [7:0] c);
    int v;
    v = int'(c) + $urandom_range(40) - 20;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // n loads, then a start; clustered runs scatter points around a few seeds
  task automatic load_and_start(input int n, input bit clustered);
    pt_t seeds[4];
    pt_t s;
    for (int i = 0; i < 4; i++) seeds[i] = 24'($urandom);
    for (int i = 0; i < n; i++) begin
      s = seeds[$urandom_range(3)];
      if (clustered) push_word(KIND_LOAD, {jitter(s[23:16]), jitter(s[15:8]), jitter(s[7:0])});
      else push_word(KIND_LOAD, 24'($urandom));
    end
    push_word(KIND_START, 24'($urandom));
  endtask

  initial begin
    int n, r, phase;
    s_tvalid = 0;
    s_tuser = KIND_LOAD;
    s_tdata = '0;
    cfg_we = 0;
    cfg_idx = CFG_CLUSTERS;
    cfg_data = '0;
    rst = 1;
    words_in = 0;
    starts = 0;
    rand_items = 0;
    rx_hold = 0;
    tx_gaps = 1;
    rx_gaps = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset settings; a start with nothing loaded yields nothing
    push_word(KIND_START, 24'hffffff);
    wait_idle();
    load_and_start(3, 0);

    set_cfg(3, 255);
    push_word(KIND_LOAD, 24'h000000);
    push_word(KIND_LOAD, 24'hffffff);
    push_word(KIND_LOAD, 24'hff00ff);
    push_word(KIND_LOAD, 24'h00ff00);
    push_word(KIND_LOAD, 24'h0f0f0f);
    push_word(KIND_START, 24'h0);

    // k of zero taken as one; zero passes emits the initial centers
    set_cfg(0, 0);
    push_word(KIND_LOAD, 24'h123456);
    push_word(KIND_LOAD, 24'habcdef);
    push_word(KIND_START, 24'h0);

    // identical points leave clusters empty; k clipped to the point count
    set_cfg(16, 5);
    for (int i = 0; i < 4; i++) push_word(KIND_LOAD, 24'h808080);
    push_word(KIND_LOAD, 24'h10f020);
    push_word(KIND_START, 24'h0);

    set_cfg(31, 1);
    load_and_start(20, 1);

    phase = 0;
    while (rand_items < 360) begin
      r = $urandom_range(99);
      tx_gaps = !(phase >= 6 && phase < 12);
      rx_gaps = tx_gaps;
      if (r < 35) begin
        r = $urandom_range(99);
        set_cfg((r < 5) ? 0 : (r < 10) ? 31 : (r < 15) ? 16 : $urandom_range(1, 16),
                (r < 8) ? 0 : (r < 12) ? 255 : $urandom_range(1, 8));
      end
      r = $urandom_range(99);
      n = (r < 8) ? 0 : (r < 15) ? $urandom_range(40, 60) : $urandom_range(1, 24);
      if (phase == 3) rx_hold = 600;
      load_and_start(n, $urandom_range(99) < 70);
      rand_items += n + 1;
      phase++;
    end
    tx_gaps = 1;
    rx_gaps = 1;

    wait_idle();
    $display("drove %0d words in %0d clustering starts; %0d centers compared",
             words_in, starts, centers_seen);
    $display("covered k from 0 to 31, 0 to 255 passes, empty clusters and empty starts");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
